>>> hdl/lhrc_pkg.sv
// ----------------------------------------------------------------------------
// lhrc_pkg
// Shared constants and types for the line hit region corner block.
// ----------------------------------------------------------------------------
`default_nettype none

package lhrc_pkg;

  // default geometry
  localparam int COORD_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 8;

  // proximity range register
  localparam int               RANGE_BITS  = 8;
  localparam logic [RANGE_BITS-1:0] RANGE_RESET = 8'd4;

  // shape of the selectable region
  typedef enum logic [1:0] {
    KIND_HORIZ = 2'd0,
    KIND_VERT  = 2'd1,
    KIND_SLANT = 2'd2
  } region_kind_t;

endpackage

`default_nettype wire

>>> hdl/line_hit_region_corners.sv
// Throughput: one beat per cycle; the division and square root chains have one
// cell per result bit, so a new segment enters every cycle.
// The whole pipeline advances together and holds while a result beat is stalled.
// Reset (rst_n low, synchronous) empties the pipeline and sets the range to 4.
// ----------------------------------------------------------------------------
// line_hit_region_corners
// Gives the four corners of the selectable band around a line segment:
// rectangles for horizontal and vertical segments, otherwise a quadrilateral
// from a fixed-point perpendicular offset (divide, square root, divide).
// ----------------------------------------------------------------------------
`default_nettype none

module line_hit_region_corners #(
  parameter int COORD_BITS = lhrc_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = lhrc_pkg::FRAC_BITS_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  cfg_we,
  input  wire logic [lhrc_pkg::RANGE_BITS-1:0]       cfg_wdata,
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic signed [COORD_BITS-1:0]          in_start_x,
  input  wire logic signed [COORD_BITS-1:0]          in_start_y,
  input  wire logic signed [COORD_BITS-1:0]          in_end_x,
  input  wire logic signed [COORD_BITS-1:0]          in_end_y,
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output lhrc_pkg::region_kind_t                     out_region_kind,
  output logic signed [COORD_BITS:0]                 out_corner_a_x,
  output logic signed [COORD_BITS:0]                 out_corner_a_y,
  output logic signed [COORD_BITS:0]                 out_corner_b_x,
  output logic signed [COORD_BITS:0]                 out_corner_b_y,
  output logic signed [COORD_BITS:0]                 out_corner_c_x,
  output logic signed [COORD_BITS:0]                 out_corner_c_y,
  output logic signed [COORD_BITS:0]                 out_corner_d_x,
  output logic signed [COORD_BITS:0]                 out_corner_d_y
);

  import lhrc_pkg::*;

  localparam int CB   = COORD_BITS;
  localparam int OW   = CB + 1;
  localparam int RB   = RANGE_BITS;
  localparam int QW   = 2 * FRAC_BITS + 2 * RB;
  localparam int SW   = FRAC_BITS + RB;
  localparam int LW   = 2 * CB + 1;
  localparam int SBW  = 6 * CB + 3;
  localparam int SB2W = SBW + SW;
  localparam int OXW  = SW - FRAC_BITS + 1;

  // sideband field positions
  localparam int P_Y2   = 0;
  localparam int P_X2   = CB;
  localparam int P_Y1   = 2 * CB;
  localparam int P_X1   = 3 * CB;
  localparam int P_ADY  = 4 * CB;
  localparam int P_ADX  = 5 * CB;
  localparam int P_NEG  = 6 * CB;
  localparam int P_KIND = 6 * CB + 1;

  logic en;

  // range register
  logic [RB-1:0] range_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_r <= RANGE_RESET;
    end else if (cfg_we) begin
      range_r <= cfg_wdata;
    end
  end

  // pipeline advances unless the result beat is held
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // stage 1: classify and take differences
  logic [OW-1:0]  dx, dy, dx_neg, dy_neg;
  logic [CB-1:0]  adx, ady;
  region_kind_t   kind;
  logic           s1_vld_r;
  logic [SBW-1:0] s1_sb_r, s1_sb_nxt;

  always_comb begin
    dx     = {in_end_x[CB-1], in_end_x} - {in_start_x[CB-1], in_start_x};
    dy     = {in_end_y[CB-1], in_end_y} - {in_start_y[CB-1], in_start_y};
    dx_neg = ~dx + {{(OW-1){1'b0}}, 1'b1};
    dy_neg = ~dy + {{(OW-1){1'b0}}, 1'b1};
    adx    = dx[OW-1] ? dx_neg[CB-1:0] : dx[CB-1:0];
    ady    = dy[OW-1] ? dy_neg[CB-1:0] : dy[CB-1:0];
    if (in_start_y == in_end_y) begin
      kind = KIND_HORIZ;
    end else if (in_start_x == in_end_x) begin
      kind = KIND_VERT;
    end else begin
      kind = KIND_SLANT;
    end
    s1_sb_nxt = {kind, (dx[OW-1] == dy[OW-1]), adx, ady,
                 in_start_x, in_start_y, in_end_x, in_end_y};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_sb_r <= s1_sb_nxt;
    end
  end

  // stage 2: squares
  logic            s2_vld_r;
  logic [SBW-1:0]  s2_sb_r;
  logic [2*CB-1:0] s2_adx2_r, s2_ady2_r;
  logic [2*RB-1:0] s2_rr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (en) begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_sb_r   <= s1_sb_r;
      s2_adx2_r <= s1_sb_r[P_ADX +: CB] * s1_sb_r[P_ADX +: CB];
      s2_ady2_r <= s1_sb_r[P_ADY +: CB] * s1_sb_r[P_ADY +: CB];
      s2_rr_r   <= range_r * range_r;
    end
  end

  // stage 3: squared length and scaled numerator
  logic                 s3_vld_r;
  logic [SBW-1:0]       s3_sb_r;
  logic [LW-1:0]        s3_len_r;
  logic [2*CB+2*RB-1:0] s3_num_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else if (en) begin
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_sb_r  <= s2_sb_r;
      s3_len_r <= {1'b0, s2_adx2_r} + {1'b0, s2_ady2_r};
      s3_num_r <= s2_ady2_r * s2_rr_r;
    end
  end

  // first divider chain: (num << 2F) / len
  logic           d1_vld [0:QW];
  logic [LW-1:0]  d1_rem [0:QW];
  logic [QW-1:0]  d1_nq  [0:QW];
  logic [LW-1:0]  d1_dv  [0:QW];
  logic [SBW-1:0] d1_sb  [0:QW];

  assign d1_vld[0] = s3_vld_r;
  assign d1_rem[0] = {1'b0, s3_num_r[2*CB+2*RB-1:2*RB]};
  assign d1_nq[0]  = {s3_num_r[2*RB-1:0], {(2*FRAC_BITS){1'b0}}};
  assign d1_dv[0]  = s3_len_r;
  assign d1_sb[0]  = s3_sb_r;

  for (genvar i = 0; i < QW; i++) begin : g_div1
    lhrc_div_cell #(
      .REMW (LW),
      .QW   (QW),
      .SBW  (SBW)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .in_vld  (d1_vld[i]),
      .in_rem  (d1_rem[i]),
      .in_nq   (d1_nq[i]),
      .in_dv   (d1_dv[i]),
      .in_sb   (d1_sb[i]),
      .out_vld (d1_vld[i+1]),
      .out_rem (d1_rem[i+1]),
      .out_nq  (d1_nq[i+1]),
      .out_dv  (d1_dv[i+1]),
      .out_sb  (d1_sb[i+1])
    );
  end

  // square root chain
  logic           sq_vld  [0:SW];
  logic [SW:0]    sq_rem  [0:SW];
  logic [SW-1:0]  sq_root [0:SW];
  logic [QW-1:0]  sq_rad  [0:SW];
  logic [SBW-1:0] sq_sb   [0:SW];

  assign sq_vld[0]  = d1_vld[QW];
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_rad[0]  = d1_nq[QW];
  assign sq_sb[0]   = d1_sb[QW];

  for (genvar i = 0; i < SW; i++) begin : g_sqrt
    lhrc_sqrt_cell #(
      .SW  (SW),
      .QW  (QW),
      .SBW (SBW)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .in_vld   (sq_vld[i]),
      .in_rem   (sq_rem[i]),
      .in_root  (sq_root[i]),
      .in_rad   (sq_rad[i]),
      .in_sb    (sq_sb[i]),
      .out_vld  (sq_vld[i+1]),
      .out_rem  (sq_rem[i+1]),
      .out_root (sq_root[i+1]),
      .out_rad  (sq_rad[i+1]),
      .out_sb   (sq_sb[i+1])
    );
  end

  // stage 4: |dx| * xq
  logic             s4_vld_r;
  logic [SB2W-1:0]  s4_sb_r;
  logic [CB+SW-1:0] s4_prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else if (en) begin
      s4_vld_r <= sq_vld[SW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_sb_r   <= {sq_root[SW], sq_sb[SW]};
      s4_prod_r <= sq_sb[SW][P_ADX +: CB] * sq_root[SW];
    end
  end

  // second divider chain: prod / |dy|
  logic            d2_vld [0:SW];
  logic [CB-1:0]   d2_rem [0:SW];
  logic [SW-1:0]   d2_nq  [0:SW];
  logic [CB-1:0]   d2_dv  [0:SW];
  logic [SB2W-1:0] d2_sb  [0:SW];

  assign d2_vld[0] = s4_vld_r;
  assign d2_rem[0] = s4_prod_r[CB+SW-1:SW];
  assign d2_nq[0]  = s4_prod_r[SW-1:0];
  assign d2_dv[0]  = s4_sb_r[P_ADY +: CB];
  assign d2_sb[0]  = s4_sb_r;

  for (genvar i = 0; i < SW; i++) begin : g_div2
    lhrc_div_cell #(
      .REMW (CB),
      .QW   (SW),
      .SBW  (SB2W)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .in_vld  (d2_vld[i]),
      .in_rem  (d2_rem[i]),
      .in_nq   (d2_nq[i]),
      .in_dv   (d2_dv[i]),
      .in_sb   (d2_sb[i]),
      .out_vld (d2_vld[i+1]),
      .out_rem (d2_rem[i+1]),
      .out_nq  (d2_nq[i+1]),
      .out_dv  (d2_dv[i+1]),
      .out_sb  (d2_sb[i+1])
    );
  end

  // output stage: round offsets and form corners
  logic [SB2W-1:0] fsb;
  logic [SW-1:0]   xq, yq;
  logic [SW:0]     xr, yr;
  logic [OW-1:0]   ox, oym, rx;
  logic [OW-1:0]   x1, y1, x2, y2;
  logic [OW-1:0]   lo_x, hi_x, lo_y, hi_y;
  logic            neg;
  region_kind_t    fkind;
  logic [OW-1:0]   c_nxt [0:7];
  logic [OW-1:0]   c_r   [0:7];
  logic            out_vld_r;
  region_kind_t    kind_r;

  always_comb begin
    fsb   = d2_sb[SW];
    xq    = fsb[SB2W-1 -: SW];
    yq    = d2_nq[SW];
    xr    = {1'b0, xq} + {{(SW+1-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};
    yr    = {1'b0, yq} + {{(SW+1-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};
    ox    = {{(OW-OXW){1'b0}}, xr[SW:FRAC_BITS]};
    oym   = {{(OW-OXW){1'b0}}, yr[SW:FRAC_BITS]};
    rx    = {{(OW-RB){1'b0}}, range_r};
    x1    = {fsb[P_X1+CB-1], fsb[P_X1 +: CB]};
    y1    = {fsb[P_Y1+CB-1], fsb[P_Y1 +: CB]};
    x2    = {fsb[P_X2+CB-1], fsb[P_X2 +: CB]};
    y2    = {fsb[P_Y2+CB-1], fsb[P_Y2 +: CB]};
    neg   = fsb[P_NEG];
    fkind = region_kind_t'(fsb[P_KIND +: 2]);
    lo_x  = ($signed(x1) < $signed(x2)) ? x1 : x2;
    hi_x  = ($signed(x1) < $signed(x2)) ? x2 : x1;
    lo_y  = ($signed(y1) < $signed(y2)) ? y1 : y2;
    hi_y  = ($signed(y1) < $signed(y2)) ? y2 : y1;
    case (fkind)
      KIND_HORIZ: begin
        c_nxt[0] = lo_x;
        c_nxt[1] = y1 - rx;
        c_nxt[2] = hi_x;
        c_nxt[3] = y1 - rx;
        c_nxt[4] = hi_x;
        c_nxt[5] = y1 + rx + {{(OW-1){1'b0}}, 1'b1};
        c_nxt[6] = lo_x;
        c_nxt[7] = y1 + rx + {{(OW-1){1'b0}}, 1'b1};
      end
      KIND_VERT: begin
        c_nxt[0] = x1 - rx;
        c_nxt[1] = lo_y;
        c_nxt[2] = x1 + rx + {{(OW-1){1'b0}}, 1'b1};
        c_nxt[3] = lo_y;
        c_nxt[4] = x1 + rx + {{(OW-1){1'b0}}, 1'b1};
        c_nxt[5] = hi_y;
        c_nxt[6] = x1 - rx;
        c_nxt[7] = hi_y;
      end
      default: begin
        c_nxt[0] = x1 + ox;
        c_nxt[1] = neg ? (y1 - oym) : (y1 + oym);
        c_nxt[2] = x1 - ox;
        c_nxt[3] = neg ? (y1 + oym) : (y1 - oym);
        c_nxt[4] = x2 - ox;
        c_nxt[5] = neg ? (y2 + oym) : (y2 - oym);
        c_nxt[6] = x2 + ox;
        c_nxt[7] = neg ? (y2 - oym) : (y2 + oym);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= d2_vld[SW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      kind_r <= fkind;
      for (int k = 0; k < 8; k++) begin
        c_r[k] <= c_nxt[k];
      end
    end
  end

  assign out_valid       = out_vld_r;
  assign out_region_kind = kind_r;
  assign out_corner_a_x  = c_r[0];
  assign out_corner_a_y  = c_r[1];
  assign out_corner_b_x  = c_r[2];
  assign out_corner_b_y  = c_r[3];
  assign out_corner_c_x  = c_r[4];
  assign out_corner_c_y  = c_r[5];
  assign out_corner_d_x  = c_r[6];
  assign out_corner_d_y  = c_r[7];

endmodule

`default_nettype wire

>>> hdl/lhrc_div_cell.sv
// ----------------------------------------------------------------------------
// lhrc_div_cell
// One restoring division step: brings down one dividend bit, trial
// subtracts the divisor and shifts one quotient bit in, then registers.
// ----------------------------------------------------------------------------
`default_nettype none

module lhrc_div_cell #(
  parameter int REMW = 33,
  parameter int QW   = 32,
  parameter int SBW  = 99
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            en,
  input  wire logic            in_vld,
  input  wire logic [REMW-1:0] in_rem,
  input  wire logic [QW-1:0]   in_nq,
  input  wire logic [REMW-1:0] in_dv,
  input  wire logic [SBW-1:0]  in_sb,
  output logic                 out_vld,
  output logic [REMW-1:0]      out_rem,
  output logic [QW-1:0]        out_nq,
  output logic [REMW-1:0]      out_dv,
  output logic [SBW-1:0]       out_sb
);

  logic            vld_r;
  logic [REMW-1:0] rem_r, rem_nxt;
  logic [QW-1:0]   nq_r, nq_nxt;
  logic [REMW-1:0] dv_r;
  logic [SBW-1:0]  sb_r;
  logic [REMW:0]   trial;
  logic [REMW:0]   diff;
  logic            take;

  // trial subtract with the next dividend bit
  always_comb begin
    trial   = {in_rem, in_nq[QW-1]};
    diff    = trial - {1'b0, in_dv};
    take    = (trial >= {1'b0, in_dv});
    rem_nxt = take ? diff[REMW-1:0] : trial[REMW-1:0];
    nq_nxt  = {in_nq[QW-2:0], take};
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  // data registers
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      nq_r  <= nq_nxt;
      dv_r  <= in_dv;
      sb_r  <= in_sb;
    end
  end

  assign out_vld = vld_r;
  assign out_rem = rem_r;
  assign out_nq  = nq_r;
  assign out_dv  = dv_r;
  assign out_sb  = sb_r;

endmodule

`default_nettype wire

>>> hdl/lhrc_sqrt_cell.sv
// ----------------------------------------------------------------------------
// lhrc_sqrt_cell
// One digit-by-digit square root step: takes two radicand bits, finds one
// root bit and registers the partial remainder and root.
// ----------------------------------------------------------------------------
`default_nettype none

module lhrc_sqrt_cell #(
  parameter int SW  = 16,
  parameter int QW  = 32,
  parameter int SBW = 99
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           en,
  input  wire logic           in_vld,
  input  wire logic [SW:0]    in_rem,
  input  wire logic [SW-1:0]  in_root,
  input  wire logic [QW-1:0]  in_rad,
  input  wire logic [SBW-1:0] in_sb,
  output logic                out_vld,
  output logic [SW:0]         out_rem,
  output logic [SW-1:0]       out_root,
  output logic [QW-1:0]       out_rad,
  output logic [SBW-1:0]      out_sb
);

  logic           vld_r;
  logic [SW:0]    rem_r, rem_nxt;
  logic [SW-1:0]  root_r, root_nxt;
  logic [QW-1:0]  rad_r, rad_nxt;
  logic [SBW-1:0] sb_r;
  logic [SW+2:0]  cur;
  logic [SW+2:0]  trial;
  logic [SW+2:0]  diff;
  logic           take;

  // trial subtract of 4*root+1
  always_comb begin
    cur      = {in_rem, in_rad[QW-1:QW-2]};
    trial    = {1'b0, in_root, 2'b01};
    diff     = cur - trial;
    take     = (cur >= trial);
    rem_nxt  = take ? diff[SW:0] : cur[SW:0];
    root_nxt = {in_root[SW-2:0], take};
    rad_nxt  = {in_rad[QW-3:0], 2'b00};
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  // data registers
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      rad_r  <= rad_nxt;
      sb_r   <= in_sb;
    end
  end

  assign out_vld  = vld_r;
  assign out_rem  = rem_r;
  assign out_root = root_r;
  assign out_rad  = rad_r;
  assign out_sb   = sb_r;

endmodule

`default_nettype wire

>>> verif/line_hit_region_corners_tb.sv
// ----------------------------------------------------------------------------
// line_hit_region_corners_tb
// Self-checking bench for the line hit region corner block. Segments are sent
// as single beats and a local fixed-point predictor works out the region kind
// and corners at the moment each beat is accepted. Result beats are checked
// in order against these predictions. The proximity range is rewritten only
// when the pipeline is empty. Both sides of the block idle and stall at random.
// ----------------------------------------------------------------------------
`default_nettype none

module line_hit_region_corners_tb;
  import lhrc_pkg::*;

  localparam int CB      = COORD_BITS_DEF;
  localparam int FB      = FRAC_BITS_DEF;
  localparam int SETTLE  = 90;
  localparam int LIMIT   = 600000;

  typedef struct {
    region_kind_t            kind;
    logic signed [CB:0]      c [8];
  } corners_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [RANGE_BITS-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [CB-1:0] in_start_x = '0, in_start_y = '0, in_end_x = '0, in_end_y = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  region_kind_t out_region_kind;
  logic signed [CB:0] out_corner_a_x, out_corner_a_y, out_corner_b_x, out_corner_b_y;
  logic signed [CB:0] out_corner_c_x, out_corner_c_y, out_corner_d_x, out_corner_d_y;

  corners_t    pending_corners [$];
  int unsigned band_range = RANGE_RESET;
  int          err_count = 0;
  int          cycle_count = 0;
  bit          send_gaps = 1'b1;
  bit          recv_stalls = 1'b1;
  int          stall_left = 0;

  line_hit_region_corners DUT (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_start_x(in_start_x), .in_start_y(in_start_y),
    .in_end_x(in_end_x), .in_end_y(in_end_y),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_region_kind(out_region_kind),
    .out_corner_a_x(out_corner_a_x), .out_corner_a_y(out_corner_a_y),
    .out_corner_b_x(out_corner_b_x), .out_corner_b_y(out_corner_b_y),
    .out_corner_c_x(out_corner_c_x), .out_corner_c_y(out_corner_c_y),
    .out_corner_d_x(out_corner_d_x), .out_corner_d_y(out_corner_d_y)
  );

  always #5 clk = ~clk;

  // integer square root, floor
  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] root;
    logic [63:0] bitv;
    root = '0;
    bitv = 64'h4000_0000_0000_0000;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v = v - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // corners of the selectable band for one segment
  function automatic corners_t band_corners(longint x1, longint y1, longint x2, longint y2,
                                            int unsigned rng);
    corners_t    res;
    longint      pt [8];
    longint      lft, rgt, top, bot, dx, dy, ox, oy;
    logic [127:0] adx, ady, len2, num;
    logic [63:0] xq, yq, quo;
    if (y1 == y2 || x1 == x2) begin
      if (y1 == y2) begin
        res.kind = KIND_HORIZ;
        lft = (x1 < x2) ? x1 : x2;
        rgt = (x1 < x2) ? x2 : x1;
        top = y1 - rng;
        bot = y1 + rng + 1;
      end else begin
        res.kind = KIND_VERT;
        lft = x1 - rng;
        rgt = x1 + rng + 1;
        top = (y1 < y2) ? y1 : y2;
        bot = (y1 < y2) ? y2 : y1;
      end
      pt = '{lft, top, rgt, top, rgt, bot, lft, bot};
    end else begin
      // perpendicular offset in fixed point, rounded half away from zero
      dx   = x2 - x1;
      dy   = y2 - y1;
      adx  = (dx < 0) ? -dx : dx;
      ady  = (dy < 0) ? -dy : dy;
      len2 = adx * adx + ady * ady;
      num  = (ady * ady * rng * rng) << (2 * FB);
      quo  = 64'(num / len2);
      xq   = int_sqrt(quo);
      yq   = 64'((adx * xq) / ady);
      ox   = longint'((xq + (64'd1 << (FB - 1))) >> FB);
      oy   = longint'((yq + (64'd1 << (FB - 1))) >> FB);
      if ((dx > 0) == (dy > 0)) oy = -oy;
      res.kind = KIND_SLANT;
      pt = '{x1 + ox, y1 + oy, x1 - ox, y1 - oy, x2 - ox, y2 - oy, x2 + ox, y2 + oy};
    end
    foreach (pt[j]) res.c[j] = pt[j][CB:0];
    return res;
  endfunction

  // one segment beat; valid is only lowered where a gap follows
  task automatic send_segment(logic signed [CB-1:0] sx, logic signed [CB-1:0] sy,
                              logic signed [CB-1:0] ex, logic signed [CB-1:0] ey);
    int gap;
    gap = send_gaps ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_start_x <= sx;
    in_start_y <= sy;
    in_end_x   <= ex;
    in_end_y   <= ey;
    do @(posedge clk); while (in_stall);
    pending_corners.push_back(band_corners(sx, sy, ex, ey, band_range));
  endtask

  // drain the pipeline, then let it settle
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_corners.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_range(int unsigned rng);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= rng[RANGE_BITS-1:0];
    @(posedge clk);
    cfg_we    <= 1'b0;
    band_range = rng;
  endtask

  // coordinate: full range, near the edges or small
  function automatic logic signed [CB-1:0] rand_coord();
    case ($urandom_range(0, 3))
      0:       return CB'($urandom);
      1:       return CB'($urandom_range(0, 300) - 32768);
      2:       return CB'(32767 - $urandom_range(0, 300));
      default: return CB'($urandom_range(0, 400) - 200);
    endcase
  endfunction

  task automatic send_random_segment();
    logic signed [CB-1:0] sx, sy, ex, ey;
    int shape;
    sx = rand_coord();
    sy = rand_coord();
    shape = $urandom_range(0, 19);
    if (shape < 2) begin
      ex = sx; ey = sy;
    end else if (shape < 5) begin
      ex = rand_coord(); ey = sy;
    end else if (shape < 8) begin
      ex = sx; ey = rand_coord();
    end else if (shape < 13) begin
      ex = sx + CB'($urandom_range(0, 40) - 20);
      ey = sy + CB'($urandom_range(0, 40) - 20);
    end else begin
      ex = rand_coord(); ey = rand_coord();
    end
    send_segment(sx, sy, ex, ey);
  endtask

  task automatic run_random(int count);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 39) == 0) send_gaps = ~send_gaps;
      if ($urandom_range(0, 39) == 0) recv_stalls = ~recv_stalls;
      send_random_segment();
    end
  endtask

  // reset range of four, without idling first
  task automatic test_reset_range();
    send_gaps = 1'b0;
    recv_stalls = 1'b0;
    send_segment(0, 0, 10, 10);
    send_segment(5, 7, 5, -9);
    send_segment(-3, 12, 40, 12);
    send_segment(100, 100, 100, 100);
    send_segment(1, 2, 3, 50);
    send_gaps = 1'b1;
    recv_stalls = 1'b1;
  endtask

  // extremes of the coordinates and of the range
  task automatic test_directed_edges();
    set_range(255);
    send_segment(-32768, -32768, 32767, -32768);
    send_segment(32767, 32767, 32767, -32768);
    send_segment(-32768, -32768, 32767, 32767);
    send_segment(32767, -32768, -32768, 32767);
    send_segment(-32768, 32767, -32767, -32768);
    send_segment(-1, -1, -1, -1);
    send_segment(0, 0, 1, -1);
    set_range(0);
    send_segment(-32768, 32767, 32767, 32767);
    send_segment(7, 9, 7, 9);
    send_segment(-32768, -5, -32768, 6);
    send_segment(3, 4, -20, 60);
    send_segment(32767, 32767, -32768, -32768);
    set_range(1);
    send_segment(0, 0, 2, 1);
    send_segment(0, 0, -1, 2);
    send_segment(10, -10, 11, -10);
  endtask

  // random segments under several ranges, pausing to drain once mid phase
  task automatic test_random_ranges();
    set_range(4);
    run_random(150);
    set_range(0);
    run_random(150);
    set_range(255);
    run_random(100);
    wait_drained();
    run_random(100);
    for (int p = 0; p < 3; p++) begin
      set_range($urandom_range(0, 255));
      run_random(150);
    end
  endtask

  // result beats: acceptance, comparison and random stalls
  always @(posedge clk) begin
    corners_t exp_c;
    logic signed [CB:0] got [8];
    string names [8];
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got   = '{out_corner_a_x, out_corner_a_y, out_corner_b_x, out_corner_b_y,
                  out_corner_c_x, out_corner_c_y, out_corner_d_x, out_corner_d_y};
        names = '{"corner_a_x", "corner_a_y", "corner_b_x", "corner_b_y",
                  "corner_c_x", "corner_c_y", "corner_d_x", "corner_d_y"};
        if (pending_corners.size() == 0) begin
          $error("result beat with nothing expected");
          err_count++;
        end else begin
          exp_c = pending_corners.pop_front();
          if (out_region_kind !== exp_c.kind) begin
            $error("region_kind expected %0d got %0d", exp_c.kind, out_region_kind);
            err_count++;
          end
          foreach (got[j]) if (got[j] !== exp_c.c[j]) begin
            $error("%s expected %0d got %0d", names[j], exp_c.c[j], got[j]);
            err_count++;
          end
        end
        stall_left = recv_stalls ? $urandom_range(0, 19) : 0;
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_stall <= (stall_left != 0);
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_range();
    test_directed_edges();
    test_random_ranges();
    wait_drained();
    if (err_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> line_hit_region_corners.f
hdl/lhrc_pkg.sv
hdl/lhrc_div_cell.sv
hdl/lhrc_sqrt_cell.sv
hdl/line_hit_region_corners.sv
verif/line_hit_region_corners_tb.sv
